/* rtl/lcd_subpixel_glyph_filter_top_assert.svh */
// Assertion helpers for the filter RTL, included by the sample queue.
// Each macro expects clk and arst_n in scope.
`ifndef LCD_SUBPIXEL_GLYPH_FILTER_TOP_ASSERT_SVH
`define LCD_SUBPIXEL_GLYPH_FILTER_TOP_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define LSGF_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("lsgf assertion failed");

// Check that a trigger implies a result in the next cycle.
`define LSGF_ASSERT_NEXT(lbl, trig, res) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (res)) \
		else $error("lsgf assertion failed");

`endif

/* rtl/lsgf_pkg.sv */
`timescale 1ns / 1ps
package lsgf_pkg;

	localparam int LEVELS    = 65;
	localparam int TAP_MAX   = 255;
	localparam int FLUSH_LEN = 4;

	typedef struct packed {
		logic [6:0] coverage;
		logic       row_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0] subpixel;
		logic       last;
	} out_item_t;

	// Sample as it travels from front to back: flush samples carry zero coverage.
	typedef struct packed {
		logic [6:0] coverage;
		logic       last;
	} q_item_t;

	typedef struct packed {
		logic we;
		logic [1:0] index;
		logic [9:0] data;
	} cfg_wr_t;

	localparam logic [1:0] REG_PRIMARY   = 2'd0;
	localparam logic [1:0] REG_SECONDARY = 2'd1;
	localparam logic [1:0] REG_TERTIARY  = 2'd2;

	localparam logic [9:0] GAIN_PRIMARY_RST   = 10'd408;
	localparam logic [9:0] GAIN_SECONDARY_RST = 10'd204;
	localparam logic [9:0] GAIN_TERTIARY_RST  = 10'd102;

	// One weighted tap: (gain * sample) >> 8, capped; out-of-range samples give zero.
	function automatic logic [7:0] tap_value(input logic [9:0] gain, input logic [6:0] s);
		logic [16:0] prod;
		logic [8:0]  shifted;
		logic [8:0]  s_ext;
		prod    = 17'(gain) * 17'(s);
		shifted = prod[16:8];
		s_ext   = {2'b00, s};
		if (s_ext >= 9'(LEVELS)) begin
			return 8'd0;
		end else if (shifted > 9'(TAP_MAX)) begin
			return 8'(TAP_MAX);
		end else begin
			return shifted[7:0];
		end
	endfunction

endpackage

/* rtl/lsgf_front.sv */
`timescale 1ns / 1ps
module lsgf_front
	import lsgf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_item_t in_data,
	input  logic     q_full,
	output logic     q_push,
	output q_item_t  q_item
);

	logic [2:0] flush_q;
	logic       in_acc;

	assign in_stall = q_full || (flush_q != 3'd0);
	assign in_acc   = in_valid && !in_stall;

	// Flush samples take priority; the input is held off until they are queued.
	always_comb begin
		q_push = 1'b0;
		q_item = '0;
		if (flush_q != 3'd0) begin
			q_push = !q_full;
			q_item.coverage = 7'd0;
			q_item.last     = (flush_q == 3'd1);
		end else if (in_acc) begin
			q_push = 1'b1;
			q_item.coverage = in_data.coverage;
			q_item.last     = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flush_q <= 3'd0;
		end else if ((flush_q != 3'd0) && q_push) begin
			flush_q <= flush_q - 3'd1;
		end else if (in_acc && in_data.row_end) begin
			flush_q <= 3'(FLUSH_LEN);
		end
	end

endmodule

/* rtl/lsgf_queue.sv */
`timescale 1ns / 1ps
module lsgf_queue
	import lsgf_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  q_item_t push_item,
	output logic    full,
	input  logic    pop,
	output logic    empty,
	output q_item_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	q_item_t       mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`include "lcd_subpixel_glyph_filter_top_assert.svh"
	`LSGF_ASSERT_ALWAYS(a_no_push_full, !(push && full))
	`LSGF_ASSERT_ALWAYS(a_no_pop_empty, !(pop && empty))
	`LSGF_ASSERT_NEXT(a_count_up, (push && !pop), (count_q == $past(count_q) + 1'b1))

endmodule

/* rtl/lsgf_back.sv */
`timescale 1ns / 1ps
module lsgf_back
	import lsgf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_wr_t   cfg,
	input  logic      q_empty,
	input  q_item_t   q_head,
	output logic      q_pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	logic [9:0]  gain_pri_q;
	logic [9:0]  gain_sec_q;
	logic [9:0]  gain_ter_q;
	logic [6:0]  hist_q [4];
	logic        out_valid_q;
	out_item_t   out_q;
	logic [10:0] sum;
	logic [7:0]  sub;

	assign q_pop = !q_empty && (!out_valid_q || !out_stall);

	always_comb begin
		sum = 11'(tap_value(gain_ter_q, q_head.coverage))
		    + 11'(tap_value(gain_sec_q, hist_q[0]))
		    + 11'(tap_value(gain_pri_q, hist_q[1]))
		    + 11'(tap_value(gain_sec_q, hist_q[2]))
		    + 11'(tap_value(gain_ter_q, hist_q[3]));
		sub = (sum > 11'(TAP_MAX)) ? 8'(TAP_MAX) : sum[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_pri_q <= GAIN_PRIMARY_RST;
			gain_sec_q <= GAIN_SECONDARY_RST;
			gain_ter_q <= GAIN_TERTIARY_RST;
		end else if (cfg.we) begin
			case (cfg.index)
				REG_PRIMARY:   gain_pri_q <= cfg.data;
				REG_SECONDARY: gain_sec_q <= cfg.data;
				REG_TERTIARY:  gain_ter_q <= cfg.data;
				default:       ;
			endcase
		end
	end

	// Four zero flush samples clear the history at row end on their own.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				hist_q[i] <= 7'd0;
			end
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				hist_q[0] <= q_head.coverage;
				hist_q[1] <= hist_q[0];
				hist_q[2] <= hist_q[1];
				hist_q[3] <= hist_q[2];
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_q.subpixel <= sub;
			out_q.last     <= q_head.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* rtl/lcd_subpixel_glyph_filter_top.sv */
`timescale 1ns / 1ps
// Data path: the accepting edge writes the sample queue; once the output register is free, a
// later edge pops the sample into the output register, and out_valid rises after that edge.
// Throughput: one transaction per cycle while the queue has room and the output is not stalled;
// a row_end transaction also makes four flush results, so the input stalls after it until
// the front has queued them. The sample queue and the single output register set this rate.
// Reset (arst_n low, asynchronous): gains return to 408/204/102, history clears.
module lcd_subpixel_glyph_filter_top
	import lsgf_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	// input channel
	input  logic       in_valid,
	output logic       in_stall,
	input  in_item_t   in_data,
	// output channel
	output logic       out_valid,
	input  logic       out_stall,
	output out_item_t  out_data,
	// configuration writes
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [9:0] cfg_data
);

	// Front to queue: expanded samples, one per input plus four flush samples at row end.
	logic    q_push;
	q_item_t q_item;
	logic    q_full;
	// Queue to back: head sample and pop.
	logic    q_pop;
	logic    q_empty;
	q_item_t q_head;
	cfg_wr_t cfg;

	// Bundle the config write so the back end sees one group.
	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	// Accept transactions and expand row ends into flush samples.
	lsgf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (q_item)
	);

	// Decouple front from back so an output stall does not block input at once.
	lsgf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_item),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	// Run the five-tap filter over the history and hold the result until taken.
	lsgf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
